>>> hw/rtl/spq_pkg.sv
`default_nettype none

package spq_pkg;

  // Default sizing
  localparam int DEPTH_DEFAULT    = 16;
  localparam int TAG_BITS_DEFAULT = 16;

  // Fixed field widths
  localparam int KEY_W     = 5;
  localparam int OUT_TAG_W = 16;
  localparam int OCC_W     = 5;
  localparam int STATUS_W  = 2;

  // Action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_code_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic         capture;
    logic         ins;
    logic         rem;
    logic         load_out;
    status_code_t status;
  } spq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
  } spq_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/spq_ctrl.sv
`default_nettype none

module spq_ctrl
  import spq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire logic      in_action,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire spq_stat_t stat,
  output spq_cmd_t       cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        action_r, action_nxt;
  logic        out_valid_r, out_valid_nxt;

  // State, held action and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      action_r    <= ACT_INSERT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      action_r    <= action_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Sequence one item: capture, then update once the result slot is free
  always_comb begin
    state_nxt     = state_r;
    action_nxt    = action_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.status    = STAT_DONE;
    in_stall      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          action_nxt  = in_action;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (action_r == ACT_REMOVE) begin
            if (stat.empty) begin
              cmd.status = STAT_EMPTY;
            end else begin
              cmd.rem = 1'b1;
            end
          end else begin
            if (stat.full) begin
              cmd.status = STAT_FULL;
            end else begin
              cmd.ins = 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> hw/rtl/spq_datapath.sv
`default_nettype none

module spq_datapath
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEPTH_DEFAULT,
  parameter int TAG_BITS    = TAG_BITS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire spq_cmd_t             cmd,
  output spq_stat_t                 stat,
  input  wire logic [KEY_W-1:0]     in_entry_key,
  input  wire logic [TAG_BITS-1:0]  in_entry_tag,
  output logic [STATUS_W-1:0]       out_status,
  output logic [KEY_W-1:0]          out_removed_key,
  output logic [OUT_TAG_W-1:0]      out_removed_tag,
  output logic                      out_head_valid,
  output logic [KEY_W-1:0]          out_head_key,
  output logic [OUT_TAG_W-1:0]      out_head_tag,
  output logic [OCC_W-1:0]          out_occupancy
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [KEY_W-1:0]    op_key_r;
  logic [TAG_BITS-1:0] op_tag_r;
  logic [CNT_W-1:0]    count_r, count_nxt;

  logic [KEY_W-1:0]    key_r   [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] tag_r   [QUEUE_DEPTH];
  logic [KEY_W-1:0]    key_nxt [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] tag_nxt [QUEUE_DEPTH];
  logic [KEY_W-1:0]    ins_key [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] ins_tag [QUEUE_DEPTH];
  logic [KEY_W-1:0]    rem_key [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] rem_tag [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] lt;

  logic [OUT_TAG_W+TAG_BITS-1:0] head_tag_ext, rem_tag_ext;
  logic [OCC_W+CNT_W-1:0]        occ_ext;

  // Hold the item's key and tag for the update cycle
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_key_r <= in_entry_key;
      op_tag_r <= in_entry_tag;
    end
  end

  // Entry count
  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_W'(QUEUE_DEPTH));

  // Row of cells: each compares against the new key and shifts in parallel
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);

    // Stored entry stays ahead of the new one
    assign lt[i] = (IDX < count_r) && (key_r[i] < op_key_r);

    // Insert source: new entry at the boundary, else the left neighbour
    if (i == 0) begin : g_first
      assign ins_key[i] = op_key_r;
      assign ins_tag[i] = op_tag_r;
    end else begin : g_rest
      assign ins_key[i] = lt[i-1] ? op_key_r : key_r[i-1];
      assign ins_tag[i] = lt[i-1] ? op_tag_r : tag_r[i-1];
    end

    // Remove source: right neighbour
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign rem_key[i] = key_r[i];
      assign rem_tag[i] = tag_r[i];
    end else begin : g_inner
      assign rem_key[i] = key_r[i+1];
      assign rem_tag[i] = tag_r[i+1];
    end

    assign key_nxt[i] = (cmd.ins && !lt[i]) ? ins_key[i] :
                        cmd.rem             ? rem_key[i] : key_r[i];
    assign tag_nxt[i] = (cmd.ins && !lt[i]) ? ins_tag[i] :
                        cmd.rem             ? rem_tag[i] : tag_r[i];

    always_ff @(posedge clk) begin
      key_r[i] <= key_nxt[i];
      tag_r[i] <= tag_nxt[i];
    end
  end

  // Fit tags and count to the result widths
  assign head_tag_ext = {{OUT_TAG_W{1'b0}}, tag_nxt[0]};
  assign rem_tag_ext  = {{OUT_TAG_W{1'b0}}, tag_r[0]};
  assign occ_ext      = {{OCC_W{1'b0}}, count_nxt};

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status      <= cmd.status;
      out_removed_key <= cmd.rem ? key_r[0] : '0;
      out_removed_tag <= cmd.rem ? rem_tag_ext[OUT_TAG_W-1:0] : '0;
      out_head_valid  <= (count_nxt != '0);
      out_head_key    <= (count_nxt != '0) ? key_nxt[0] : '0;
      out_head_tag    <= (count_nxt != '0) ? head_tag_ext[OUT_TAG_W-1:0] : '0;
      out_occupancy   <= occ_ext[OCC_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sorted_priority_queue.sv
// Channel | Direction | Handshake         | Payload
// in_     | input     | in_valid/in_stall | action, entry_key, entry_tag
// out_    | output    | out_valid/out_stall | status, removed_key/tag, head_valid,
//         |           |                   | head_key/tag, occupancy
//
// Each item is first captured; then the row of cells compares against the key
// and shifts the whole list in parallel.
// The update waits while a previous result is still stalled at the output;
// the input stays stalled until that update has been done.
// Reset (rst_n low, synchronous) empties the queue; stored entries are not cleared.
`default_nettype none

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEPTH_DEFAULT,
  parameter int TAG_BITS    = TAG_BITS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_action,
  input  wire logic [KEY_W-1:0]     in_entry_key,
  input  wire logic [TAG_BITS-1:0]  in_entry_tag,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [STATUS_W-1:0]       out_status,
  output logic [KEY_W-1:0]          out_removed_key,
  output logic [OUT_TAG_W-1:0]      out_removed_tag,
  output logic                      out_head_valid,
  output logic [KEY_W-1:0]          out_head_key,
  output logic [OUT_TAG_W-1:0]      out_head_tag,
  output logic [OCC_W-1:0]          out_occupancy
);

  spq_cmd_t  cmd;
  spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  spq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_entry_key    (in_entry_key),
    .in_entry_tag    (in_entry_tag),
    .out_status      (out_status),
    .out_removed_key (out_removed_key),
    .out_removed_tag (out_removed_tag),
    .out_head_valid  (out_head_valid),
    .out_head_key    (out_head_key),
    .out_head_tag    (out_head_tag),
    .out_occupancy   (out_occupancy)
  );

  // Never insert into a full queue
  a_no_ins_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |-> !stat.full)
    else $error("insert issued while queue full");

  // A captured item blocks further input until it is processed
  a_busy_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> in_stall)
    else $error("input not stalled after capture");

  // A loaded result is presented next cycle
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");

  // A performed remove reports success
  a_remove_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rem |=> (out_status == STAT_DONE))
    else $error("remove reported with wrong status");

endmodule

`default_nettype wire
